// ===== rtl/lkv_pkg.sv =====
// shared constants, types and state encoding for the lru key-value cache
package lkv_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 16;
	localparam int VAL_W    = 31;
	localparam logic [IDX_W-1:0] RANK_OLDEST = IDX_W'(CAPACITY - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RESULT
	} lkv_state_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic decide;
		logic result;
	} lkv_cmd_t;

	typedef struct packed {
		logic issue_done;
		logic scan_busy;
		logic out_busy;
	} lkv_stat_t;

endpackage

// ===== rtl/lkv_ctrl.sv =====
// controller state machine: accept, key scan, decide and update, result load
module lkv_ctrl import lkv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lkv_stat_t stat,
	output lkv_cmd_t  cmd
);

	lkv_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!stat.issue_done) begin
					cmd.issue = 1'b1;
				end else if (!stat.scan_busy) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_RESULT;
			end
			ST_RESULT: begin
				if (!stat.out_busy) begin
					cmd.result = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lkv_datapath.sv =====
// datapath: key and value memories, recency ranks, scan pipeline, output register
module lkv_datapath import lkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lkv_cmd_t         cmd,
	output lkv_stat_t        stat,
	input  logic             mode,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0] store_value,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             hit,
	output logic [VAL_W-1:0] read_value,
	output logic             evicted
);

	logic [KEY_W-1:0] key_mem [CAPACITY];
	logic [VAL_W-1:0] val_mem [CAPACITY];
	logic [IDX_W-1:0] rank_q  [CAPACITY];

	logic             req_mode_q;
	logic [KEY_W-1:0] req_key_q;
	logic [VAL_W-1:0] req_val_q;

	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] idx_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [KEY_W-1:0] key_rd_s1;

	logic             found_q;
	logic [IDX_W-1:0] match_slot_q;
	logic [IDX_W-1:0] match_rank_q;
	logic [IDX_W-1:0] victim_slot_q;
	logic             evict_q;
	logic [VAL_W-1:0] val_rd_q;

	logic             out_valid_q;
	logic             hit_q;
	logic [VAL_W-1:0] read_value_q;
	logic             evicted_q;

	logic             full;
	logic             put_miss;
	logic             upd;
	logic [IDX_W-1:0] slot_sel;
	logic [CNT_W-1:0] bound;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_mode_q <= mode;
			req_key_q  <= lookup_key;
			req_val_q  <= store_value;
		end
	end

	// slot and aging bound for the update
	always_comb begin
		full     = (used_q == CNT_W'(CAPACITY));
		put_miss = req_mode_q && !found_q;
		upd      = req_mode_q || found_q;
		if (found_q) begin
			slot_sel = match_slot_q;
			bound    = CNT_W'(match_rank_q);
		end else if (full) begin
			slot_sel = victim_slot_q;
			bound    = CNT_W'(RANK_OLDEST);
		end else begin
			slot_sel = used_q[IDX_W-1:0];
			bound    = used_q;
		end
	end

	// key memory: scan read, write on insert
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			key_rd_s1 <= key_mem[idx_q[IDX_W-1:0]];
		end
		if (cmd.decide && put_miss) begin
			key_mem[slot_sel] <= req_key_q;
		end
	end

	// value memory: read and write at the chosen slot
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			val_rd_q <= val_mem[slot_sel];
			if (req_mode_q) begin
				val_mem[slot_sel] <= req_val_q;
			end
		end
	end

	// scan pipeline and match tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			v_s1    <= 1'b0;
			idx_s1  <= '0;
			found_q <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			idx_s1 <= idx_q[IDX_W-1:0];
			if (cmd.load) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (v_s1 && !found_q && key_rd_s1 == req_key_q) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !found_q && key_rd_s1 == req_key_q) begin
			match_slot_q <= idx_s1;
			match_rank_q <= rank_q[idx_s1];
		end
		if (v_s1 && rank_q[idx_s1] == RANK_OLDEST) begin
			victim_slot_q <= idx_s1;
		end
		if (cmd.decide) begin
			evict_q <= put_miss && full;
		end
	end

	// recency ranks and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.decide) begin
			if (put_miss && !full) begin
				used_q <= used_q + 1'b1;
			end
			if (upd) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (IDX_W'(i) == slot_sel) begin
						rank_q[i] <= '0;
					end else if (CNT_W'(i) < used_q && CNT_W'(rank_q[i]) < bound) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			hit_q        <= found_q;
			read_value_q <= (!req_mode_q && found_q) ? val_rd_q : '0;
			evicted_q    <= evict_q;
		end
	end

	assign stat.issue_done = (idx_q == used_q);
	assign stat.scan_busy  = v_s1;
	assign stat.out_busy   = out_valid_q && !out_ready;

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign evicted    = evicted_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> idx_q < used_q)
		else $error("scan read past filled entries");

	a_decide_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.decide |-> !v_s1)
		else $error("decision before scan drained");

	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decide && put_miss && !full) |=> used_q == $past(used_q) + 1'b1)
		else $error("insert into free slot did not advance fill count");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && evicted_q))
		else $error("hit and eviction reported together");

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// top level of the lru key-value cache: controller plus datapath
//
//  channel | handshake            | beat fields
//  input   | in_valid / in_ready  | mode, lookup_key, store_value
//  output  | out_valid / out_ready| hit, read_value, evicted
//
// an item passes accept, then the key scan (one key memory read per filled entry, a compare
// drain and a handoff to decide), then decide and update, and result load
// reset clears the fill count, ranks and handshake state; memories are not cleared
// a new beat is taken once the previous result sits in the output register
// a stalled output holds the next result in the result state until taken
module lru_key_value_cache import lkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             mode,
	input  logic [KEY_W-1:0] lookup_key,
	input  logic [VAL_W-1:0] store_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             hit,
	output logic [VAL_W-1:0] read_value,
	output logic             evicted
);

	lkv_cmd_t  cmd;
	lkv_stat_t stat;

	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lkv_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted)
	);

endmodule
